// ----- design/pwl_pixel_compress_defines.svh -----
// ----------------------------------------------------------------------------
// pwl_pixel_compress_defines
// Assertion macros shared by the pixel compressor; clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef PWL_PIXEL_COMPRESS_DEFINES_SVH
`define PWL_PIXEL_COMPRESS_DEFINES_SVH

// same-cycle implication
`define PWLPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PWLPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pwlpc_pkg.sv -----
// ----------------------------------------------------------------------------
// pwlpc_pkg
// Widths, register indexes, configuration record and curve helpers of the
// piecewise linear pixel compressor.
// ----------------------------------------------------------------------------
package pwlpc_pkg;

  localparam int PIXEL_W    = 32;
  localparam int CODE_W     = 16;
  localparam int GAIN_W     = 32;
  localparam int NUM_X_REGS = 4;
  localparam int PT_IDX_W   = 2;
  localparam int NPTS_W     = 3;
  localparam int YS_W       = NUM_X_REGS * CODE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PROD_W     = 2 * PIXEL_W;

  localparam int MAX_POINTS_DEF     = 4;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_POINTS = 3'd0,
    REG_POINT_X0   = 3'd1,
    REG_POINT_X1   = 3'd2,
    REG_POINT_X2   = 3'd3,
    REG_POINT_X3   = 3'd4,
    REG_POINT_YS   = 3'd5
  } cfg_reg_t;

  // live curve settings
  typedef struct packed {
    logic [NPTS_W-1:0]                  num_points;
    logic [NUM_X_REGS-1:0][PIXEL_W-1:0] point_x;
    logic [YS_W-1:0]                    point_ys;
  } cfg_t;

  // index of the last control point in use, count clamped to 1..max_points
  function automatic logic [PT_IDX_W-1:0] last_point(input logic [NPTS_W-1:0] num_points,
                                                     input int max_points);
    logic [NPTS_W-1:0] n;
    n = num_points;
    if (n == '0) n = NPTS_W'(1);
    if (n > NPTS_W'(max_points)) n = NPTS_W'(max_points);
    return PT_IDX_W'(n - NPTS_W'(1));
  endfunction

  // y of control point k
  function automatic logic [CODE_W-1:0] y_of(input logic [YS_W-1:0] ys,
                                             input logic [PT_IDX_W-1:0] k);
    return ys[CODE_W*k +: CODE_W];
  endfunction

endpackage

// ----- design/pwl_pixel_compress.sv -----
// ----------------------------------------------------------------------------
// pwl_pixel_compress
// Piecewise linear pixel compressor: 32-bit pixels to 16-bit codes through a
// curve of up to four control points, with per-segment gains from a divider.
//
//   channel   dir   payload                       handshake
//   s_*       in    tdata=pixel, tlast=frame_end  tvalid/tready
//   m_*       out   tdata=code, tlast=frame_end   tvalid/tready
//   cfg_*     in    index 0..5, 64-bit data       cfg_we, no read-back
//
// One pixel per cycle while no gain pass runs and m_tready does not stall;
// each result is registered in stage 1, stage 2, stage 3 and the output.
// After reset and after each register write the gain divider works through at
// most MAX_POINTS-1 segments, each a load step and then one step per numerator
// bit, and s_tready stays low until it finishes.
// A stall on m_tready fills the bubbles and then holds every stage.
// ----------------------------------------------------------------------------
`include "pwl_pixel_compress_defines.svh"

module pwl_pixel_compress import pwlpc_pkg::*; #(
  parameter int MAX_POINTS     = MAX_POINTS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIXEL_W-1:0]    s_tdata,   // pixel
  input  logic                  s_tlast,   // frame_end
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [CODE_W-1:0]     m_tdata,   // code
  output logic                  m_tlast    // frame_end_out
);

  cfg_t                              cfg;
  logic                              restart;
  logic                              busy;
  logic [MAX_POINTS-2:0][GAIN_W-1:0] gains;

  // a write to a defined register starts a new gain pass
  assign restart = cfg_we && (cfg_index <= REG_POINT_YS);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_points <= NPTS_W'(2);
      cfg.point_x[0] <= '0;
      cfg.point_x[1] <= '1;
      cfg.point_x[2] <= '0;
      cfg.point_x[3] <= '0;
      cfg.point_ys   <= YS_W'(64'hFFFF_0000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_POINTS: cfg.num_points <= cfg_data[NPTS_W-1:0];
        REG_POINT_X0:   cfg.point_x[0] <= cfg_data[PIXEL_W-1:0];
        REG_POINT_X1:   cfg.point_x[1] <= cfg_data[PIXEL_W-1:0];
        REG_POINT_X2:   cfg.point_x[2] <= cfg_data[PIXEL_W-1:0];
        REG_POINT_X3:   cfg.point_x[3] <= cfg_data[PIXEL_W-1:0];
        REG_POINT_YS:   cfg.point_ys   <= cfg_data[YS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // gain divider
  pwlpc_gain_div #(
    .MAX_POINTS     (MAX_POINTS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_gain_div (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .busy    (busy),
    .gains   (gains)
  );

  // pixel pipeline
  pwlpc_pipe #(
    .MAX_POINTS     (MAX_POINTS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_pipe (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .gains    (gains),
    .busy     (busy),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // checks
  `PWLPC_ASSERT_NEXT(a_write_starts_pass, restart, busy, "register write did not start gain pass")
  `PWLPC_ASSERT_NOW(a_pass_after_reset, $fell(rst), busy, "no gain pass after reset")
  `PWLPC_ASSERT_NOW(a_no_pixel_in_pass, busy, !(s_tvalid && s_tready), "pixel taken during gain pass")

endmodule

// ----- design/pwlpc_gain_div.sv -----
// ----------------------------------------------------------------------------
// pwlpc_gain_div
// Segment gain sequencer: walks the segments and runs a restoring divider,
// one quotient bit per cycle, for round(dy * 2^F / dx) with saturation.
// ----------------------------------------------------------------------------
module pwlpc_gain_div import pwlpc_pkg::*; #(
  parameter int MAX_POINTS     = MAX_POINTS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cfg_t                                  cfg,
  input  logic                                  restart,
  output logic                                  busy,
  output logic [MAX_POINTS-2:0][GAIN_W-1:0]     gains
);

  localparam int NSEG  = MAX_POINTS - 1;
  localparam int SEG_W = (NSEG > 1) ? $clog2(NSEG) : 1;
  localparam int NUM_W = ((GAIN_FRAC_BITS + CODE_W > PIXEL_W - 1) ?
                          (GAIN_FRAC_BITS + CODE_W) : (PIXEL_W - 1)) + 1;
  localparam int CNT_W = $clog2(NUM_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_DIV  = 3'b100
  } div_state_t;

  div_state_t          state;
  logic [SEG_W-1:0]    seg;
  logic [CNT_W-1:0]    cnt;
  logic [PIXEL_W-1:0]  dvs;
  logic [PIXEL_W-1:0]  rem;
  logic [NUM_W-1:0]    quo;

  logic [PT_IDX_W-1:0] pt_l, pt_r, last_pt;
  logic [PIXEL_W-1:0]  xl, xr, span;
  logic [CODE_W-1:0]   yl, yr, dy;
  logic                seg_ok, seg_last;
  logic [NUM_W-1:0]    num_init;
  logic [PIXEL_W:0]    trial, trial_sub;
  logic                take;
  logic [PIXEL_W-1:0]  rem_nx;
  logic [NUM_W-1:0]    quo_nx;
  logic [PROD_W-1:0]   q_ext;
  logic [GAIN_W-1:0]   q_sat;

  // operands of the current segment
  always_comb begin
    pt_l     = PT_IDX_W'(seg);
    pt_r     = pt_l + PT_IDX_W'(1);
    last_pt  = last_point(cfg.num_points, MAX_POINTS);
    xl       = cfg.point_x[pt_l];
    xr       = cfg.point_x[pt_r];
    yl       = y_of(cfg.point_ys, pt_l);
    yr       = y_of(cfg.point_ys, pt_r);
    span     = xr - xl;
    dy       = yr - yl;
    seg_ok   = (pt_r <= last_pt) && (xr > xl) && (yr >= yl);
    seg_last = (seg == SEG_W'(NSEG - 1));
    num_init = (NUM_W'(dy) << GAIN_FRAC_BITS) + NUM_W'(span >> 1);
  end

  // one restoring division step
  always_comb begin
    trial     = {rem, quo[NUM_W-1]};
    trial_sub = trial - {1'b0, dvs};
    take      = (trial >= {1'b0, dvs});
    rem_nx    = take ? trial_sub[PIXEL_W-1:0] : trial[PIXEL_W-1:0];
    quo_nx    = {quo[NUM_W-2:0], take};
    q_ext     = PROD_W'(quo_nx);
    q_sat     = (|q_ext[PROD_W-1:GAIN_W]) ? '1 : q_ext[GAIN_W-1:0];
  end

  // sequencer, restarted by reset and by every write to a defined register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      seg   <= '0;
    end else if (restart) begin
      state <= ST_LOAD;
      seg   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
        end
        ST_LOAD: begin
          if (seg_ok) begin
            state <= ST_DIV;
          end else if (seg_last) begin
            state <= ST_IDLE;
          end else begin
            seg <= seg + SEG_W'(1);
          end
        end
        ST_DIV: begin
          if (cnt == '0) begin
            if (seg_last) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_LOAD;
              seg   <= seg + SEG_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // divider datapath and gain table
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      dvs <= span;
      rem <= '0;
      quo <= num_init;
      cnt <= CNT_W'(NUM_W - 1);
      if (!seg_ok) gains[seg] <= '0;
    end else if (state == ST_DIV) begin
      rem <= rem_nx;
      quo <= quo_nx;
      cnt <= cnt - CNT_W'(1);
      if (cnt == '0) gains[seg] <= q_sat;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// ----- design/pwlpc_pipe.sv -----
// ----------------------------------------------------------------------------
// pwlpc_pipe
// Four-stage pixel pipeline: range compare and segment pick, offset and
// operand select, gain multiply, round, add and saturate.
// ----------------------------------------------------------------------------
module pwlpc_pipe import pwlpc_pkg::*; #(
  parameter int MAX_POINTS     = MAX_POINTS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cfg_t                              cfg,
  input  logic [MAX_POINTS-2:0][GAIN_W-1:0] gains,
  input  logic                              busy,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [PIXEL_W-1:0]                s_tdata,   // pixel
  input  logic                              s_tlast,   // frame_end
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [CODE_W-1:0]                 m_tdata,   // code
  output logic                              m_tlast    // frame_end_out
);

  localparam int NSEG  = MAX_POINTS - 1;
  localparam int SEG_W = (NSEG > 1) ? $clog2(NSEG) : 1;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (GAIN_FRAC_BITS - 1);

  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_LAST  = 2'd1,
    MODE_SEG   = 2'd2
  } pix_mode_t;

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1, v2, v3;

  // stage 1 registers
  logic [PIXEL_W-1:0]  p1_pixel;
  logic                p1_last;
  pix_mode_t           p1_mode;
  logic [SEG_W-1:0]    p1_seg;
  // stage 2 registers
  logic [PIXEL_W-1:0]  p2_dx;
  logic [GAIN_W-1:0]   p2_gain;
  logic [CODE_W-1:0]   p2_y;
  logic                p2_last;
  // stage 3 registers
  logic [PROD_W-1:0]   p3_prod;
  logic [CODE_W-1:0]   p3_y;
  logic                p3_last;

  logic [PT_IDX_W-1:0] last_pt;
  pix_mode_t           mode0;
  logic [SEG_W-1:0]    seg0;
  logic [PT_IDX_W-1:0] seg_pt;
  logic [PIXEL_W-1:0]  dx1;
  logic [CODE_W-1:0]   y1;
  logic [PROD_W-1:0]   inc;
  logic [CODE_W:0]     sum;
  logic [CODE_W-1:0]   code;

  // backpressure chain
  assign rdy4     = !m_tvalid || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1 && !busy;

  assign last_pt = last_point(cfg.num_points, MAX_POINTS);

  // stage 0: clamp compares and highest segment start at or below the pixel
  always_comb begin
    seg0 = '0;
    for (int j = 0; j < NSEG; j++) begin
      if ((PT_IDX_W'(j + 1) <= last_pt) && (cfg.point_x[j] <= s_tdata)) seg0 = SEG_W'(j);
    end
    if (s_tdata <= cfg.point_x[0]) mode0 = MODE_FIRST;
    else if (s_tdata >= cfg.point_x[last_pt]) mode0 = MODE_LAST;
    else mode0 = MODE_SEG;
  end

  // stage 1: offset into the segment; clamped pixels get a zero offset
  always_comb begin
    seg_pt = PT_IDX_W'(p1_seg);
    case (p1_mode)
      MODE_FIRST: begin
        dx1 = '0;
        y1  = y_of(cfg.point_ys, '0);
      end
      MODE_LAST: begin
        dx1 = '0;
        y1  = y_of(cfg.point_ys, last_pt);
      end
      default: begin
        dx1 = p1_pixel - cfg.point_x[seg_pt];
        y1  = y_of(cfg.point_ys, seg_pt);
      end
    endcase
  end

  // stage 3: round, add to the segment start and saturate
  always_comb begin
    inc  = (p3_prod + HALF) >> GAIN_FRAC_BITS;
    sum  = {1'b0, p3_y} + {1'b0, inc[CODE_W-1:0]};
    code = ((|inc[PROD_W-1:CODE_W]) || sum[CODE_W]) ? '1 : sum[CODE_W-1:0];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid && s_tready;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) m_tvalid <= v3;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1_pixel <= s_tdata;
      p1_last  <= s_tlast;
      p1_mode  <= mode0;
      p1_seg   <= seg0;
    end
    if (rdy2) begin
      p2_dx   <= dx1;
      p2_gain <= gains[p1_seg];
      p2_y    <= y1;
      p2_last <= p1_last;
    end
    if (rdy3) begin
      p3_prod <= PROD_W'(p2_dx) * PROD_W'(p2_gain);
      p3_y    <= p2_y;
      p3_last <= p2_last;
    end
    if (rdy4) begin
      m_tdata <= code;
      m_tlast <= p3_last;
    end
  end

endmodule

// ----- dv/pwl_pixel_compress_tb.sv -----
// ----------------------------------------------------------------------------
// pwl_pixel_compress_tb
// Self-checking bench for the piecewise linear pixel compressor. Curves are
// loaded through the register port while the stream is drained, pixels are
// pushed with random gaps and backpressure, and every code is checked against
// a local model of the curve and its rounded segment gains.
// ----------------------------------------------------------------------------
module pwl_pixel_compress_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwlpc_pkg::*;

  localparam int NPTS_MAX  = MAX_POINTS_DEF;
  localparam int FRAC_BITS = GAIN_FRAC_BITS_DEF;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               frame_end;
  } pixel_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              frame_end;
  } code_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_NUM_POINTS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIXEL_W-1:0]    s_tdata = '0;   // pixel
  logic                  s_tlast = 1'b0; // frame_end
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [CODE_W-1:0]     m_tdata;        // code
  logic                  m_tlast;        // frame_end_out

  // curve mirror, updated on every register write
  logic [NPTS_W-1:0]  curve_npts = NPTS_W'(2);
  logic [PIXEL_W-1:0] curve_x [NUM_X_REGS] = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0};
  logic [YS_W-1:0]    curve_ys = 64'h0000_0000_FFFF_0000;
  logic [GAIN_W-1:0]  seg_gain [NPTS_MAX-1];

  pixel_item_t pixel_q[$];
  code_item_t  code_q[$];
  int          err_cnt = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left;

  pwl_pixel_compress uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic int unsigned pts_used();
    int unsigned n;
    n = curve_npts;
    if (n < 1) n = 1;
    if (n > NPTS_MAX) n = NPTS_MAX;
    return n;
  endfunction

  function automatic logic [CODE_W-1:0] y_at(int unsigned k);
    return curve_ys[CODE_W*k +: CODE_W];
  endfunction

  // rounded gain per segment; zero for unused, flat-x or falling-y segments
  function automatic void refresh_gains();
    int unsigned       n;
    logic [31:0]       dx;
    logic [CODE_W-1:0] dy;
    logic [63:0]       den;
    logic [63:0]       num;
    logic [63:0]       quo;
    n = pts_used();
    for (int j = 0; j < NPTS_MAX - 1; j++) begin
      seg_gain[j] = '0;
      if (j + 1 < n && curve_x[j+1] > curve_x[j] && y_at(j + 1) >= y_at(j)) begin
        dx  = curve_x[j+1] - curve_x[j];
        dy  = y_at(j + 1) - y_at(j);
        den = {32'h0, dx};
        num = ({48'h0, dy} << FRAC_BITS) + den / 2;
        quo = num / den;
        seg_gain[j] = (quo > 64'h0000_0000_FFFF_FFFF) ? '1 : quo[31:0];
      end
    end
  endfunction

  function automatic logic [CODE_W-1:0] compress_pixel(logic [PIXEL_W-1:0] pixel);
    int unsigned n;
    int unsigned seg;
    logic [31:0] dx;
    logic [63:0] prod;
    logic [63:0] sum;
    n = pts_used();
    if (pixel <= curve_x[0]) return y_at(0);
    if (pixel >= curve_x[n-1]) return y_at(n - 1);
    seg = 0;
    for (int j = 0; j + 1 < n; j++)
      if (curve_x[j] <= pixel) seg = j;
    dx   = pixel - curve_x[seg];
    prod = {32'h0, dx} * {32'h0, seg_gain[seg]};
    sum  = {48'h0, y_at(seg)} + ((prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    return (sum > 64'h0000_0000_0000_FFFF) ? '1 : sum[CODE_W-1:0];
  endfunction

  function automatic void log_mismatch(string what, logic [31:0] want, logic [31:0] got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch: %s expected %h got %h at %0t", what, want, got, $realtime);
  endfunction

  // ---------------------------------------------------------------- driver

  // pixel source; predicts the code on each accepted transaction
  always @(posedge clk) begin
    pixel_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        code_q.push_back('{code: compress_pixel(s_tdata), frame_end: s_tlast});
      if (!s_tvalid || s_tready) begin
        if (pixel_q.size() != 0 && (quiet || $urandom_range(99) >= 17)) begin
          nxt = pixel_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.pixel;
          s_tlast  <= nxt.frame_end;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, armed from the stimulus
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= 300;
      hold_req = 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // code sink backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 17);
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    code_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (code_q.size() == 0) begin
        log_mismatch("code with no pixel pending", 32'h0, {16'h0, m_tdata});
      end else begin
        want = code_q.pop_front();
        if (m_tdata !== want.code)
          log_mismatch("code", {16'h0, want.code}, {16'h0, m_tdata});
        if (m_tlast !== want.frame_end)
          log_mismatch("frame end", {31'h0, want.frame_end}, {31'h0, m_tlast});
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pixel_q.size() != 0 || s_tvalid || code_q.size() != 0);
  endtask

  // one register write; then let the gain divider finish
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NUM_POINTS: curve_npts = val[NPTS_W-1:0];
      REG_POINT_X0, REG_POINT_X1, REG_POINT_X2, REG_POINT_X3:
        curve_x[PT_IDX_W'(idx - REG_POINT_X0)] = val[PIXEL_W-1:0];
      REG_POINT_YS: curve_ys = val;
      default: ;
    endcase
    refresh_gains();
    repeat (2) @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic load_curve(logic [NPTS_W-1:0] npts, logic [31:0] x0, logic [31:0] x1,
                            logic [31:0] x2, logic [31:0] x3, logic [63:0] ys);
    wait_drained();
    repeat (8) @(posedge clk);
    write_reg(REG_NUM_POINTS, {61'h0, npts});
    write_reg(REG_POINT_X0, {32'h0, x0});
    write_reg(REG_POINT_X1, {32'h0, x1});
    write_reg(REG_POINT_X2, {32'h0, x2});
    write_reg(REG_POINT_X3, {32'h0, x3});
    write_reg(REG_POINT_YS, ys);
  endtask

  task automatic send(logic [31:0] pixel, bit fe);
    pixel_q.push_back('{pixel: pixel, frame_end: fe});
  endtask

  // sorted curve with random scale, or raw random values when broken
  task automatic random_curve(bit broken);
    int unsigned xs[$];
    int unsigned ys[$];
    int unsigned scale;
    int unsigned base;
    scale = $urandom_range(4, 32);
    base  = ($urandom_range(3) == 0) ? 0 : $urandom;
    for (int k = 0; k < NUM_X_REGS; k++) begin
      xs.push_back(broken ? $urandom : base + ($urandom >> (32 - scale)));
      ys.push_back($urandom_range(16'hFFFF));
    end
    if (!broken) begin
      xs.sort();
      ys.sort();
      if ($urandom_range(5) == 0) begin
        xs[0] = 0;
        xs[3] = 32'hFFFF_FFFF;
        ys[3] = 16'hFFFF;
      end
    end
    load_curve(broken ? NPTS_W'($urandom_range(7)) : NPTS_W'($urandom_range(1, 4)),
               xs[0], xs[1], xs[2], xs[3],
               {ys[3][15:0], ys[2][15:0], ys[1][15:0], ys[0][15:0]});
  endtask

  // pixels clustered at control points and inside the curve, plus raw noise
  task automatic random_pixels(int count);
    int unsigned pick;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [63:0] span;
    logic [31:0] pixel;
    lo = curve_x[0];
    hi = curve_x[pts_used() - 1];
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        pixel = curve_x[$urandom_range(3)] + $urandom_range(8) - 4;
      end else if (pick < 80 && hi > lo) begin
        span  = {32'h0, hi - lo} + 64'd1;
        pixel = lo + 32'({$urandom, $urandom} % span);
      end else begin
        pixel = $urandom;
      end
      send(pixel, $urandom_range(15) == 0 || i == count - 1);
    end
  endtask

  initial begin
    refresh_gains();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset curve: ends, middle, and the saturating top
    send(32'h0, 1'b0);
    send(32'h1, 1'b1);
    send(32'h7FFF_FFFF, 1'b0);
    send(32'hFFFF_FFFE, 1'b0);
    send(32'hFFFF_FFFF, 1'b1);

    // full four-point curve: every point, its neighbors and each segment
    load_curve(NPTS_W'(4), 32'd100, 32'd1000, 32'd70000, 32'hF000_0000,
               {16'hFFFF, 16'd40000, 16'd300, 16'd10});
    send(32'h0, 1'b0);
    send(32'd100, 1'b0);
    send(32'd101, 1'b0);
    send(32'd550, 1'b0);
    send(32'd1000, 1'b0);
    send(32'd1001, 1'b0);
    send(32'd69999, 1'b0);
    send(32'd70000, 1'b0);
    send(32'h8000_0000, 1'b0);
    send(32'hEFFF_FFFF, 1'b0);
    send(32'hF000_0000, 1'b0);
    send(32'hFFFF_FFFF, 1'b1);

    // zero point count acts as a single point
    wait_drained();
    repeat (8) @(posedge clk);
    write_reg(REG_NUM_POINTS, '0);
    send(32'h0, 1'b0);
    send(32'd5000, 1'b0);
    send(32'hFFFF_FFFF, 1'b1);

    // count above range, folded-back x and falling y
    load_curve(NPTS_W'(7), 32'd100, 32'd1000, 32'd500, 32'hF000_0000,
               {16'd200, 16'd50000, 16'd300, 16'd10});
    send(32'd700, 1'b0);
    send(32'd2000, 1'b0);
    send(32'hA000_0000, 1'b1);

    // random curves
    for (int ph = 0; ph < 14; ph++) begin
      random_curve(ph % 4 == 3);
      case (ph)
        2: begin
          quiet = 1'b1;
          random_pixels(150);
          wait_drained();
          quiet = 1'b0;
        end
        4: begin
          quiet = 1'b1;
          hold_req = 1'b1;
          random_pixels(120);
          wait_drained();
          quiet = 1'b0;
        end
        6: begin
          random_pixels(55);
          wait_drained();
          random_pixels(55);
        end
        default: random_pixels(110);
      endcase
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (code_q.size() != 0)
      log_mismatch("codes never produced", 32'h0, code_q.size());
    if (err_cnt == 0)
      $display("pwl_pixel_compress_tb: done, clean");
    else
      $display("pwl_pixel_compress_tb: done, errors");
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("pwl_pixel_compress_tb: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/pwlpc_pkg.sv
design/pwlpc_gain_div.sv
design/pwlpc_pipe.sv
design/pwl_pixel_compress.sv
dv/pwl_pixel_compress_tb.sv
